>>> src/qidfe_pkg.sv
`default_nettype none
package qidfe_pkg;

	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_END = 8'h7F;
	localparam logic [6:0] QUOTE = 7'h27;
	localparam logic [6:0] CHAR_I = 7'h69;
	localparam logic [6:0] CHAR_D = 7'h64;
	localparam logic [6:0] CHAR_EQ = 7'h3D;

	localparam int LONG_LEN = 12;

	// automaton codes: 0..11 bytes of the long key matched, or the short key up to '='
	localparam logic [3:0] KEY_IDLE = 4'd0;
	localparam logic [3:0] KEY_I = 4'd1;
	localparam logic [3:0] KEY_ID = 4'd2;
	localparam logic [3:0] KEY_IDETUDI = 4'd7;
	localparam logic [3:0] KEY_LONG_LAST = 4'd11;
	localparam logic [3:0] KEY_SHORT_EQ = 4'd12;

	localparam logic [6:0] LONG_KEY [LONG_LEN] = '{
		7'h69, 7'h64, 7'h45, 7'h74, 7'h75, 7'h64,
		7'h69, 7'h61, 7'h6E, 7'h74, 7'h3D, 7'h27
	};

	typedef struct packed {
		logic [3:0] state;
		logic       hit;
	} key_next_t;

	typedef struct packed {
		logic busy;
		logic bank;
	} back_stat_t;

	function automatic key_next_t key_step(input logic [3:0] st, input logic [6:0] c);
		key_next_t r;
		r.state = KEY_IDLE;
		r.hit = 1'b0;
		if (st < 4'(LONG_LEN) && c == LONG_KEY[st]) begin
			if (st == KEY_LONG_LAST) begin
				r.hit = 1'b1;
			end else begin
				r.state = 4'(st + 4'd1);
			end
		end else if (st == KEY_ID && c == CHAR_EQ) begin
			r.state = KEY_SHORT_EQ;
		end else if (st == KEY_IDETUDI && c == CHAR_D) begin
			// fall back to the "id" suffix
			r.state = KEY_ID;
		end else if (st == KEY_SHORT_EQ && c == QUOTE) begin
			r.hit = 1'b1;
		end else if (c == CHAR_I) begin
			r.state = KEY_I;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/qidfe_front.sv
`default_nettype none
module qidfe_front
	import qidfe_pkg::*;
#(
	parameter int ID_SLOTS = 32,
	localparam int IDX_W = $clog2(ID_SLOTS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [7:0]       rx_byte,
	input  wire logic             hold_full,
	output logic                  full,
	output logic                  wr_en,
	output logic [IDX_W:0]        wr_addr,
	output logic [6:0]            wr_data,
	output logic                  desc_push,
	output logic                  desc_bank,
	output logic [IDX_W-1:0]      desc_len
);

	localparam logic [IDX_W-1:0] MAX_CNT = IDX_W'(ID_SLOTS - 1);

	logic [3:0]       key_q;
	logic             cap_q;
	logic [IDX_W-1:0] cnt_q;
	logic             ovf_q;
	logic             bank_q;

	logic      accept;
	logic      printable;
	logic      is_quote;
	key_next_t nxt;

	assign full = hold_full;
	assign accept = push && !hold_full;
	assign printable = rx_byte >= PRINT_LO && rx_byte < PRINT_END;
	assign is_quote = rx_byte[6:0] == QUOTE;
	assign nxt = key_step(key_q, rx_byte[6:0]);

	assign wr_en = accept && printable && cap_q && !is_quote && cnt_q < MAX_CNT;
	assign wr_addr = {bank_q, cnt_q};
	assign wr_data = rx_byte[6:0];

	assign desc_push = accept && printable && cap_q && is_quote && cnt_q != '0 && !ovf_q;
	assign desc_bank = bank_q;
	assign desc_len = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= KEY_IDLE;
			cap_q <= 1'b0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			bank_q <= 1'b0;
		end else if (accept && printable) begin
			if (cap_q) begin
				if (!is_quote) begin
					if (cnt_q < MAX_CNT) begin
						cnt_q <= IDX_W'(cnt_q + 1'b1);
					end else begin
						ovf_q <= 1'b1;
					end
				end else begin
					// closing quote: hand the bank over if the identifier is kept, and start searching again
					if (desc_push) begin
						bank_q <= !bank_q;
					end
					cap_q <= 1'b0;
					cnt_q <= '0;
					ovf_q <= 1'b0;
					key_q <= KEY_IDLE;
				end
			end else if (nxt.hit) begin
				cap_q <= 1'b1;
				cnt_q <= '0;
				ovf_q <= 1'b0;
				key_q <= KEY_IDLE;
			end else begin
				key_q <= nxt.state;
			end
		end
	end

endmodule
`default_nettype wire

>>> src/qidfe_desc_fifo.sv
`default_nettype none
module qidfe_desc_fifo #(
	parameter int W = 6
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	input  wire logic         pop,
	output logic              nonempty,
	output logic [W-1:0]      head,
	output logic [1:0]        count
);

	logic [W-1:0] data_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	logic do_push;
	logic do_pop;

	assign do_push = push && count_q != 2'd2;
	assign do_pop = pop && count_q != 2'd0;
	assign nonempty = count_q != 2'd0;
	assign head = data_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= 2'(count_q + {1'b0, do_push} - {1'b0, do_pop});
		end
	end

endmodule
`default_nettype wire

>>> src/qidfe_back.sv
`default_nettype none
module qidfe_back
	import qidfe_pkg::*;
#(
	parameter int ID_SLOTS = 32,
	localparam int IDX_W = $clog2(ID_SLOTS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [IDX_W:0]   wr_addr,
	input  wire logic [6:0]       wr_data,
	input  wire logic             desc_valid,
	input  wire logic             desc_bank,
	input  wire logic [IDX_W-1:0] desc_len,
	output logic                  desc_pop,
	output back_stat_t            stat,
	input  wire logic             pop,
	output logic                  empty,
	output logic [6:0]            id_char,
	output logic [4:0]            id_length,
	output logic                  is_final
);

	localparam int DEPTH = 1 << (IDX_W + 1);

	logic [6:0] mem [DEPTH];

	logic             busy_q;
	logic             bank_q;
	logic [IDX_W-1:0] len_q;
	logic [IDX_W-1:0] idx_q;

	logic       rd_pend_s1;
	logic [6:0] rd_data_s1;
	logic [4:0] rd_len_s1;
	logic       rd_final_s1;

	logic       out_valid_q;
	logic [6:0] out_char_q;
	logic [4:0] out_len_q;
	logic       out_final_q;

	logic        issue;
	logic        last;
	logic [31:0] len_ext;

	assign desc_pop = !busy_q && desc_valid;
	assign issue = busy_q && !rd_pend_s1 && (!out_valid_q || pop);
	assign last = idx_q == IDX_W'(len_q - 1'b1);
	assign len_ext = 32'(len_q);
	assign stat.busy = busy_q;
	assign stat.bank = bank_q;

	assign empty = !out_valid_q;
	assign id_char = out_char_q;
	assign id_length = out_len_q;
	assign is_final = out_final_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= mem[{bank_q, idx_q}];
			rd_len_s1 <= len_ext[4:0];
			rd_final_s1 <= last;
		end
		if (rd_pend_s1) begin
			out_char_q <= rd_data_s1;
			out_len_q <= rd_len_s1;
			out_final_q <= rd_final_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bank_q <= 1'b0;
			len_q <= '0;
			idx_q <= '0;
			rd_pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (desc_pop) begin
				busy_q <= 1'b1;
				bank_q <= desc_bank;
				len_q <= desc_len;
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= IDX_W'(idx_q + 1'b1);
				// the bank is free once its last byte has been read
				if (last) begin
					busy_q <= 1'b0;
				end
			end
			rd_pend_s1 <= issue;
			if (rd_pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

>>> src/quoted_id_field_extractor.sv
`default_nettype none
// Pulls quoted identifiers out of a serial byte stream. Bytes outside 0x20..0x7E are
// ignored; after either key idEtudiant=' or id=' the bytes up to the next quote form
// the identifier, which comes out one byte per beat with its length and a final mark
// on its last byte. Empty identifiers and those longer than ID_SLOTS-1 bytes are
// dropped. The parser takes one byte every cycle while full is low; full rises only
// while two complete identifiers are held, queued or being drained, since the value
// memory has two banks of ID_SLOTS entries, one being drained while the other fills.
// The drain side registers each byte read from the value memory and starts no new
// read while one is pending. The memory needs no clearing after reset.
module quoted_id_field_extractor
	import qidfe_pkg::*;
#(
	parameter int ID_SLOTS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] rx_byte,
	output logic            empty,
	input  wire logic       pop,
	output logic [6:0]      id_char,
	output logic [4:0]      id_length,
	output logic            is_final
);

	localparam int IDX_W = $clog2(ID_SLOTS);

	logic             wr_en;
	logic [IDX_W:0]   wr_addr;
	logic [6:0]       wr_data;
	logic             desc_push;
	logic             desc_bank;
	logic [IDX_W-1:0] desc_len;
	logic             desc_pop;
	logic             desc_valid;
	logic [IDX_W:0]   desc_head;
	logic [1:0]       q_count;
	back_stat_t       stat;
	logic [1:0]       held;
	logic             hold_full;

	assign held = 2'(q_count + {1'b0, stat.busy});
	assign hold_full = held == 2'd2;

	qidfe_front #(.ID_SLOTS(ID_SLOTS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.rx_byte   (rx_byte),
		.hold_full (hold_full),
		.full      (full),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.desc_push (desc_push),
		.desc_bank (desc_bank),
		.desc_len  (desc_len)
	);

	qidfe_desc_fifo #(.W(IDX_W + 1)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (desc_push),
		.push_data ({desc_bank, desc_len}),
		.pop       (desc_pop),
		.nonempty  (desc_valid),
		.head      (desc_head),
		.count     (q_count)
	);

	qidfe_back #(.ID_SLOTS(ID_SLOTS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.desc_valid (desc_valid),
		.desc_bank  (desc_head[IDX_W]),
		.desc_len   (desc_head[IDX_W-1:0]),
		.desc_pop   (desc_pop),
		.stat       (stat),
		.pop        (pop),
		.empty      (empty),
		.id_char    (id_char),
		.id_length  (id_length),
		.is_final   (is_final)
	);

`ifndef ASSERT_OFF
	// never more identifiers held than there are banks
	a_held_max: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_count == 2'd2 && stat.busy))
		else $error("more identifiers held than banks");

	// the filling bank is never the one being drained
	a_bank_split: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && stat.busy |-> wr_addr[IDX_W] != stat.bank)
		else $error("write into bank under drain");

	// a handed-over identifier always has at least one byte and room in the queue
	a_desc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		desc_push |-> desc_len != '0 && q_count != 2'd2)
		else $error("bad identifier hand-over");
`endif

endmodule
`default_nettype wire

>>> tb/qidfe_checker.sv
module qidfe_checker
	import qidfe_pkg::*;
#(
	parameter int ID_SLOTS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic       full,
	input  wire logic [7:0] rx_byte,
	input  wire logic       empty,
	input  wire logic       pop,
	input  wire logic [6:0] id_char,
	input  wire logic [4:0] id_length,
	input  wire logic       is_final,
	output int              fail_count,
	output int              beats_due
);

	localparam int SHORT_LEN = 4;
	localparam logic [6:0] SHORT_KEY [SHORT_LEN] = '{CHAR_I, CHAR_D, CHAR_EQ, QUOTE};

	typedef struct packed {
		logic [6:0] ch;
		logic [4:0] len;
		logic       fin;
	} id_beat_t;

	id_beat_t   expected_beats [$];
	logic [3:0] key_progress;
	logic       in_value;
	logic [6:0] value_bytes [ID_SLOTS];
	logic [5:0] value_len;
	logic       value_too_long;
	int         errors;

	// longest suffix of the matched text plus c that is still a prefix of either key
	function automatic logic [3:0] scan_key(input logic [3:0] st, input logic [6:0] c,
			output logic hit);
		logic [6:0] text [LONG_LEN + 1];
		int n;
		int len;
		int k;
		logic found;
		logic same;
		logic [3:0] nxt;
		hit = 1'b0;
		found = 1'b0;
		nxt = KEY_IDLE;
		n = 0;
		if (st == KEY_SHORT_EQ) begin
			for (k = 0; k < 3; k++)
				text[k] = SHORT_KEY[k];
			n = 3;
		end else if (st < 4'(LONG_LEN)) begin
			for (k = 0; k < int'(st); k++)
				text[k] = LONG_KEY[k];
			n = int'(st);
		end
		text[n] = c;
		n++;
		for (len = n; len >= 1; len--) begin
			if (!found && len <= LONG_LEN) begin
				same = 1'b1;
				for (k = 0; k < len; k++)
					if (text[n - len + k] != LONG_KEY[k])
						same = 1'b0;
				if (same) begin
					found = 1'b1;
					if (len == LONG_LEN)
						hit = 1'b1;
					else
						nxt = 4'(len);
				end
			end
			if (!found && len <= SHORT_LEN) begin
				same = 1'b1;
				for (k = 0; k < len; k++)
					if (text[n - len + k] != SHORT_KEY[k])
						same = 1'b0;
				if (same) begin
					found = 1'b1;
					if (len == SHORT_LEN)
						hit = 1'b1;
					else if (len == 3)
						nxt = KEY_SHORT_EQ;
					else
						nxt = 4'(len);
				end
			end
		end
		return nxt;
	endfunction

	task automatic absorb_byte(input logic [7:0] c);
		id_beat_t b;
		logic hit;
		int k;
		if (c >= PRINT_LO && c < PRINT_END) begin
			if (in_value) begin
				if (c[6:0] != QUOTE) begin
					if (value_len < 6'(ID_SLOTS - 1)) begin
						value_bytes[value_len] = c[6:0];
						value_len++;
					end else begin
						value_too_long = 1'b1;
					end
				end else begin
					if (value_len >= 1 && !value_too_long) begin
						for (k = 0; k < int'(value_len); k++) begin
							b.ch = value_bytes[k];
							b.len = 5'(value_len);
							b.fin = (k == int'(value_len) - 1);
							expected_beats.push_back(b);
						end
					end
					in_value = 1'b0;
					value_len = '0;
					value_too_long = 1'b0;
					key_progress = KEY_IDLE;
				end
			end else begin
				key_progress = scan_key(key_progress, c[6:0], hit);
				if (hit) begin
					in_value = 1'b1;
					value_len = '0;
					value_too_long = 1'b0;
					key_progress = KEY_IDLE;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		id_beat_t want;
		if (!arst_n) begin
			expected_beats.delete();
			key_progress = KEY_IDLE;
			in_value = 1'b0;
			value_len = '0;
			value_too_long = 1'b0;
			errors = 0;
			fail_count <= 0;
			beats_due <= 0;
		end else begin
			if (push && !full)
				absorb_byte(rx_byte);
			if (pop && !empty) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: unexpected beat, expected none, got char %h len %0d final %b",
						$time, id_char, id_length, is_final);
					errors++;
				end else begin
					want = expected_beats.pop_front();
					if (id_char !== want.ch) begin
						$display("%0t: id_char expected %h got %h", $time, want.ch, id_char);
						errors++;
					end
					if (id_length !== want.len) begin
						$display("%0t: id_length expected %0d got %0d", $time, want.len,
							id_length);
						errors++;
					end
					if (is_final !== want.fin) begin
						$display("%0t: is_final expected %b got %b", $time, want.fin, is_final);
						errors++;
					end
				end
			end
			fail_count <= errors;
			beats_due <= expected_beats.size();
		end
	end

endmodule

>>> tb/tb.sv
module tb;
	import qidfe_pkg::*;

	localparam int RANDOM_ITEMS = 480;
	localparam int CALM_ITEMS = 60;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 24;
	localparam int STALL_LIMIT = 3000;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] rx_byte;
	logic       empty;
	logic       pop;
	logic [6:0] id_char;
	logic [4:0] id_length;
	logic       is_final;
	int         fail_count;
	int         beats_due;
	int         stall_cycles;
	int         printable_sent;
	bit         calm;
	bit         hold_go;

	quoted_id_field_extractor i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.rx_byte  (rx_byte),
		.empty    (empty),
		.pop      (pop),
		.id_char  (id_char),
		.id_length(id_length),
		.is_final (is_final)
	);

	qidfe_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.rx_byte   (rx_byte),
		.empty     (empty),
		.pop       (pop),
		.id_char   (id_char),
		.id_length (id_length),
		.is_final  (is_final),
		.fail_count(fail_count),
		.beats_due (beats_due)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
			$display("Regression FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic [7:0] value_char();
		logic [7:0] v;
		do
			v = 8'($urandom_range(32, 126));
		while (v[6:0] == QUOTE);
		return v;
	endfunction

	function automatic logic [7:0] junk_byte();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(0, 31));
		return 8'($urandom_range(127, 255));
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (!calm && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 16);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (full);
		if (b >= PRINT_LO && b < PRINT_END)
			printable_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_record();
		int kind;
		int n;
		int i;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			// well-formed key, value and closing quote
			n = $urandom_range(0, 2);
			for (i = 0; i < n; i++)
				send_byte(8'($urandom_range(32, 126)));
			if ($urandom_range(0, 1))
				send_text("idEtudiant='");
			else
				send_text("id='");
			case ($urandom_range(0, 19))
				0: n = 0;
				1: n = 31;
				2: n = $urandom_range(32, 35);
				default: n = $urandom_range(1, 12);
			endcase
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_byte(junk_byte());
				send_byte(value_char());
			end
			send_text("'");
		end else if (kind < 85) begin
			// truncated long key, then a tail that may or may not complete a key
			n = $urandom_range(1, LONG_LEN - 1);
			for (i = 0; i < n; i++)
				send_byte({1'b0, LONG_KEY[i]});
			if ($urandom_range(0, 1)) begin
				send_text("d='");
			end else begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++)
					send_byte($urandom_range(0, 3) == 0 ? {1'b0, QUOTE} : value_char());
			end
		end else begin
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++)
				send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int burst_left;
		int hold_left;
		bit held;
		burst_left = 0;
		hold_left = 0;
		held = 1'b0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !held) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
				pop <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				burst_left = $urandom_range(1, 16) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		rx_byte = '0;
		calm = 1'b0;
		hold_go = 1'b0;
		printable_sent = 0;
		stall_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fallback from idEtudi to id, ignored bytes inside a key, empty value
		send_text("i");
		send_byte(8'h1F);
		send_text("d");
		send_byte(8'h00);
		send_text("Etudid=");
		send_byte(8'h7F);
		send_text("''");
		// long key, key text inside the value, printable extremes
		send_text("idEtudiant='");
		send_byte(8'hFF);
		send_text(" id=~'");

		printable_sent = 0;
		hold_go = 1'b1;
		while (printable_sent < RANDOM_ITEMS) begin
			if (printable_sent >= RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			send_record();
		end
		// close any value still open so its beats are flushed
		send_text("'");
		push <= 1'b0;
		// let the checker take in the last byte before its count is read
		@(posedge clk);

		while (beats_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (beats_due != 0)
			$display("%0t: %0d expected beats never arrived", $time, beats_due);
		if (fail_count == 0 && beats_due == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> files.f
src/qidfe_pkg.sv
src/qidfe_front.sv
src/qidfe_desc_fifo.sv
src/qidfe_back.sv
src/quoted_id_field_extractor.sv
tb/qidfe_checker.sv
tb/tb.sv
